// ===== rtl/chacha20_keystream_block_macros.svh =====
// ----------------------------------------------------------------------------
// ChaCha20 keystream block assertion macros
// Shared assertion forms for the checker of the keystream block.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_KEYSTREAM_BLOCK_MACROS_SVH
`define CHACHA20_KEYSTREAM_BLOCK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CC20KS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CC20KS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cc20ks_pkg.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 keystream package
// Widths, quarter-round index tables and the per-step round function.
// ----------------------------------------------------------------------------
`default_nettype none

package cc20ks_pkg;

    localparam int unsigned WORDS             = 16;
    localparam int unsigned CFG_REGS          = 8;
    localparam int unsigned CFG_DATA_W        = 64;
    localparam int unsigned ADDR_W            = 6;
    localparam int unsigned IDX_W             = 4;
    localparam int unsigned STEPS_PER_DROUND  = 8;
    localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
    localparam int unsigned COUNTER_WORD      = 12;

    typedef logic [WORDS-1:0][31:0] t_state;

    // [diagonal][quarter][a,b,c,d]
    localparam int unsigned QIDX [2][4][4] = '{
        '{'{0, 4,  8, 12}, '{1, 5,  9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15}},
        '{'{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7,  8, 13}, '{3, 4,  9, 14}}
    };

    localparam int unsigned ROT [4] = '{16, 12, 8, 7};

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // One add/xor/rotate line of all four quarter rounds of a round.
    // step[2] picks column or diagonal round, step[1:0] the line.
    function automatic t_state qr_step(input t_state s, input logic [2:0] step);
        t_state      r;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned d;
        logic [31:0] x;
        r = s;
        for (int q = 0; q < 4; q++) begin
            a = QIDX[step[2]][q][0];
            b = QIDX[step[2]][q][1];
            c = QIDX[step[2]][q][2];
            d = QIDX[step[2]][q][3];
            if (step[0] == 1'b0) begin
                r[a] = r[a] + r[b];
                x    = r[d] ^ r[a];
                r[d] = rotl32(x, ROT[step[1:0]]);
            end else begin
                r[c] = r[c] + r[d];
                x    = r[b] ^ r[c];
                r[b] = rotl32(x, ROT[step[1:0]]);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/chacha20_keystream_block.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 keystream block
// Pipelined ChaCha20 block function: one block index in, sixteen keystream
// words out, with the sixteenth word flagged.
// ----------------------------------------------------------------------------
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+---------------------------
// input     | in        | i_in_valid / o_in_ready    | i_block_index
// output    | out       | o_out_valid / i_out_ready  | o_word_index, o_key_word,
//           |           |                            | o_last_word
// config    | in        | psel, penable, pwrite      | paddr, pwdata, prdata
// ----------------------------------------------------------------------------
// Each round line (add, xor, rotate of all four quarter rounds) is one
// register stage: 8*DOUBLE_ROUNDS stages plus an entry and a final-add stage.
// A block holds the output until its sixteen words are taken one by one.
// The whole pipe advances together whenever its last stage is empty or is
// being unloaded into the output buffer; nothing is dropped on a stall.
// Synchronous active-low reset clears valid bits, counter and config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_keystream_block #(
    parameter int unsigned DOUBLE_ROUNDS = cc20ks_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [31:0]                         i_block_index,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [cc20ks_pkg::IDX_W-1:0]             o_word_index,
    output logic [31:0]                              o_key_word,
    output logic                                     o_last_word,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [cc20ks_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [cc20ks_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cc20ks_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                     pready
);

    localparam int unsigned NSTG = cc20ks_pkg::STEPS_PER_DROUND * DOUBLE_ROUNDS;

    logic [cc20ks_pkg::CFG_DATA_W-1:0] r_cfg [cc20ks_pkg::CFG_REGS];

    cc20ks_pkg::t_state r_st  [NSTG+1];
    logic [31:0]        r_idx [NSTG+1];
    logic               r_vld [NSTG+1];

    logic [31:0]                   r_ser_word [cc20ks_pkg::WORDS];
    logic                          r_ser_vld;
    logic [cc20ks_pkg::IDX_W-1:0]  r_cnt;

    cc20ks_pkg::t_state base;
    cc20ks_pkg::t_state entry_st;
    cc20ks_pkg::t_state final_base;
    logic               out_fire;
    logic               ser_load;
    logic               adv;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = r_cfg[paddr[cc20ks_pkg::ADDR_W-1:3]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cc20ks_pkg::CFG_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            r_cfg[paddr[cc20ks_pkg::ADDR_W-1:3]] <= pwdata;
        end
    end

    always_comb begin
        for (int i = 0; i < cc20ks_pkg::CFG_REGS; i++) begin
            base[2*i]   = r_cfg[i][31:0];
            base[2*i+1] = r_cfg[i][63:32];
        end
    end

    // add the block index into the counter word, on entry and at the final add
    always_comb begin
        entry_st   = base;
        entry_st[cc20ks_pkg::COUNTER_WORD] =
            base[cc20ks_pkg::COUNTER_WORD] + i_block_index;
        final_base = base;
        final_base[cc20ks_pkg::COUNTER_WORD] =
            base[cc20ks_pkg::COUNTER_WORD] + r_idx[NSTG];
    end

    // ---------------- flow control ----------------
    assign out_fire   = o_out_valid && i_out_ready;
    assign ser_load   = !r_ser_vld || (out_fire && o_last_word);
    assign adv        = !r_vld[NSTG] || ser_load;
    assign o_in_ready = adv;

    // ---------------- entry stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st[0]  <= entry_st;
            r_idx[0] <= i_block_index;
        end
    end

    // ---------------- round line stages ----------------
    for (genvar k = 1; k <= NSTG; k++) begin : g_stage
        localparam logic [2:0] STEP = 3'((k - 1) % cc20ks_pkg::STEPS_PER_DROUND);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (adv) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_st[k]  <= cc20ks_pkg::qr_step(r_st[k-1], STEP);
                r_idx[k] <= r_idx[k-1];
            end
        end
    end

    // ---------------- final add and word buffer ----------------
    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            for (int i = 0; i < cc20ks_pkg::WORDS; i++) begin
                r_ser_word[i] <= r_st[NSTG][i] + final_base[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_vld <= 1'b0;
            r_cnt     <= '0;
        end else if (ser_load) begin
            r_ser_vld <= r_vld[NSTG];
            r_cnt     <= '0;
        end else if (out_fire) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_out_valid  = r_ser_vld;
    assign o_word_index = r_cnt;
    assign o_key_word   = r_ser_word[r_cnt];
    assign o_last_word  = (r_cnt == cc20ks_pkg::IDX_W'(cc20ks_pkg::WORDS - 1));

endmodule

`default_nettype wire

// ===== rtl/cc20ks_checker.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 keystream checker
// Port-level checks of the word sequence on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chacha20_keystream_block_macros.svh"

module cc20ks_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire logic [cc20ks_pkg::IDX_W-1:0]    o_word_index,
    input wire logic [31:0]                     o_key_word,
    input wire logic                            o_last_word
);

    // a stalled word holds
    `CC20KS_ASSERT_NEXT(a_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_key_word) && $stable(o_word_index), "output word changed while stalled")

    `CC20KS_ASSERT_NOW(a_last_flag, o_out_valid, o_last_word == (o_word_index == 4'd15), "last flag does not match word index 15")

    // words of one block come back to back in index order
    `CC20KS_ASSERT_NEXT(a_advance, o_out_valid && i_out_ready && !o_last_word, o_out_valid && (o_word_index == $past(o_word_index) + 4'd1), "block words not contiguous")

    `CC20KS_ASSERT_NEXT(a_restart, o_out_valid && i_out_ready && o_last_word, !o_out_valid || (o_word_index == 4'd0), "new block does not start at word zero")

endmodule

bind chacha20_keystream_block cc20ks_checker u_cc20ks_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_word_index (o_word_index),
    .o_key_word   (o_key_word),
    .o_last_word  (o_last_word)
);

`default_nettype wire
